>>> rtl/wrs_pkg.sv
package wrs_pkg;

  localparam int NUM_WARPS     = 8;
  localparam int NUM_REG_TYPES = 2;
  localparam int REGS_PER_TYPE = 32;
  localparam int NUM_SOURCES   = 3;

  localparam int NUM_LANES   = NUM_SOURCES + 1;
  localparam int NUM_BANKS   = NUM_WARPS * NUM_REG_TYPES;
  localparam int NUM_SLOTS   = NUM_BANKS * REGS_PER_TYPE;
  localparam int MAX_REPORTS = 64;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int T_W    = (NUM_REG_TYPES > 1) ? $clog2(NUM_REG_TYPES) : 1;
  localparam int RI_W   = $clog2(REGS_PER_TYPE);
  localparam int LANE_W = $clog2(NUM_LANES);
  localparam int REP_W  = $clog2(MAX_REPORTS + 1);

  localparam int TYPE_W = 2;
  localparam int IDX_W  = 5;
  localparam int REC_W  = 28;
  localparam int CNT_W  = 8;

  typedef enum logic [2:0] {
    MODE_CHECK    = 3'd0,
    MODE_USES     = 3'd1,
    MODE_RESERVE  = 3'd2,
    MODE_RELEASE  = 3'd3,
    MODE_COMMIT   = 3'd4,
    MODE_SNAPSHOT = 3'd5,
    MODE_RESTORE  = 3'd6
  } mode_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  warp;
    logic        write_back;
    logic [6:0]  dst_reg;
    logic [6:0]  src_reg_0;
    logic [6:0]  src_reg_1;
    logic [6:0]  src_reg_2;
    logic [15:0] owner_tag;
    logic [3:0]  owner_unit;
    logic [7:0]  owner_op;
    logic [7:0]  packet_count;
  } in_item_t;

  typedef struct packed {
    logic        last;
    logic        report;
    logic        hazard;
    logic        done_res;
    logic        error;
    logic [1:0]  reg_type;
    logic [4:0]  reg_index;
    logic [15:0] owner_tag_out;
    logic [3:0]  owner_unit_out;
    logic [7:0]  owner_op_out;
  } out_item_t;

  typedef logic [NUM_REG_TYPES-1:0][REGS_PER_TYPE-1:0] busy_row_t;

  typedef struct packed {
    logic              ok;
    logic              busy;
    logic [BANK_W-1:0] bank;
    logic [SLOT_W-1:0] slot;
    logic [TYPE_W-1:0] rtype;
    logic [IDX_W-1:0]  ridx;
  } lane_t;

  function automatic logic [BANK_W-1:0] bank_of(input logic [2:0] warp, input int tsel);
    return BANK_W'(int'(warp) * NUM_REG_TYPES + tsel);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [2:0] warp, input int tsel,
                                               input int idx);
    return SLOT_W'((int'(warp) * NUM_REG_TYPES + tsel) * REGS_PER_TYPE + idx);
  endfunction

endpackage

>>> rtl/wrs_if.sv
interface wrs_in_if;
  logic               valid;
  logic               ready;
  wrs_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface wrs_out_if;
  logic               valid;
  logic               ready;
  wrs_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/warp_register_scoreboard.sv
// Per-warp register scoreboard. Each item is accepted only while the block is idle and runs to
// completion before the next one is taken; a finished result may still wait in the output
// register while the next item enters. Check, reserve, release, commit and restore each pass
// through accept, memory read, and update with the result loaded into the output register.
// Uses examines its lanes in turn (destination and sources, decoded side by side in parallel
// lanes) and reports each busy register found. Snapshot walks every register of the warp in
// turn, clearing and reporting each owned register up to MAX_REPORTS. Downstream stalls can
// hold any item. After reset the block clears its commit counts and deferred-valid flags
// across all NUM_SLOTS (512) slots and accepts no item until that pass ends.
module warp_register_scoreboard (
  input logic      clk,
  input logic      rst,
  wrs_in_if.sink   req,
  wrs_out_if.source rsp
);
  import wrs_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_LOAD   = 7'b0000100,
    ST_OP     = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_FETCH  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;
  in_item_t item;

  logic [REGS_PER_TYPE-1:0] busy [NUM_BANKS];
  busy_row_t busy_row;
  lane_t lane_info [NUM_LANES];
  logic [6:0] lane_code [NUM_LANES];
  logic [6:0] src_codes [3];
  logic [NUM_LANES-1:0] mask;

  logic [SLOT_W-1:0] clr_addr;
  logic [LANE_W-1:0] lane_sel;
  logic [T_W-1:0]    scan_t;
  logic [RI_W-1:0]   scan_i;
  logic [REP_W-1:0]  rep_cnt;
  logic              scan_end;
  logic [TYPE_W-1:0] cur_type;
  logic [IDX_W-1:0]  cur_idx;
  logic              held_v;
  logic [TYPE_W-1:0] held_type;
  logic [IDX_W-1:0]  held_idx;
  logic [REC_W-1:0]  held_rec;
  logic              res_err, res_hz, res_done;

  logic        ov;
  out_item_t   opay;
  logic        out_free;
  logic        emit;
  out_item_t   emit_pay;

  logic              busy_we, busy_val;
  logic [BANK_W-1:0] busy_bank;
  logic [RI_W-1:0]   busy_bit;
  logic              own_we, def_we, cnt_we, dv_we, rd_en;
  logic [SLOT_W-1:0] own_waddr, cnt_waddr, dv_waddr, rd_addr;
  logic [REC_W-1:0]  own_wdata, own_rd, def_rd, rec_in;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rd, cnt_inc;
  logic              dv_wdata, dv_rd;

  logic is_uses, is_snap, warp_ok, bad, go_scan;
  logic op_err, op_hz, op_done;
  logic found, snap_hit, scan_last;
  logic [SLOT_W-1:0] scan_slot;
  lane_t l0;

  assign src_codes[0] = item.src_reg_0;
  assign src_codes[1] = item.src_reg_1;
  assign src_codes[2] = item.src_reg_2;
  assign rec_in = {item.owner_tag, item.owner_unit, item.owner_op};
  assign warp_ok = int'(item.warp) < NUM_WARPS;

  for (genvar t = 0; t < NUM_REG_TYPES; t++) begin : g_row
    assign busy_row[t] = warp_ok ? busy[bank_of(item.warp, t)] : '0;
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    if (i == 0) begin : g_dst
      assign lane_code[i] = item.dst_reg;
      assign mask[i] = item.write_back && lane_info[i].ok && lane_info[i].busy;
    end else begin : g_src
      assign lane_code[i] = src_codes[i-1];
      assign mask[i] = lane_info[i].ok && lane_info[i].busy;
    end
    wrs_lane u_lane (
      .warp     (item.warp),
      .reg_code (lane_code[i]),
      .busy_row (busy_row),
      .info     (lane_info[i])
    );
  end

  assign l0 = lane_info[0];
  assign is_uses = item.mode == MODE_USES;
  assign is_snap = item.mode == MODE_SNAPSHOT;
  assign bad = !warp_ok || (item.mode > MODE_RESTORE);
  assign go_scan = !bad && (is_uses || is_snap);
  assign out_free = !ov || rsp.ready;
  assign cnt_inc = (cnt_rd == '1) ? cnt_rd : cnt_rd + CNT_W'(1);
  assign snap_hit = busy_row[scan_t][scan_i] && (rep_cnt < REP_W'(MAX_REPORTS));
  assign scan_slot = is_uses ? lane_info[lane_sel].slot : slot_of(item.warp, int'(scan_t),
                                                                  int'(scan_i));
  assign scan_last = is_uses ? (lane_sel == LANE_W'(NUM_LANES - 1))
                             : ((scan_t == T_W'(NUM_REG_TYPES - 1))
                                && (scan_i == RI_W'(REGS_PER_TYPE - 1)));

  function automatic out_item_t make_item(input logic lst, input logic rep, input logic hz,
                                          input logic dn, input logic er,
                                          input logic [TYPE_W-1:0] ty,
                                          input logic [IDX_W-1:0] ix,
                                          input logic [REC_W-1:0] rc);
    out_item_t o;
    o.last           = lst;
    o.report         = rep;
    o.hazard         = hz;
    o.done_res       = dn;
    o.error          = er;
    o.reg_type       = ty;
    o.reg_index      = ix;
    o.owner_tag_out  = rc[27:12];
    o.owner_unit_out = rc[11:8];
    o.owner_op_out   = rc[7:0];
    return o;
  endfunction

  always_comb begin
    state_next = state;
    emit = 1'b0;
    emit_pay = '0;
    busy_we = 1'b0;
    busy_val = 1'b0;
    busy_bank = l0.bank;
    busy_bit = RI_W'(l0.ridx);
    own_we = 1'b0;
    own_waddr = l0.slot;
    own_wdata = rec_in;
    def_we = 1'b0;
    cnt_we = 1'b0;
    cnt_waddr = l0.slot;
    cnt_wdata = '0;
    dv_we = 1'b0;
    dv_waddr = l0.slot;
    dv_wdata = 1'b0;
    rd_en = 1'b0;
    rd_addr = l0.slot;
    op_err = 1'b0;
    op_hz = 1'b0;
    op_done = 1'b0;
    found = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cnt_we = 1'b1;
        cnt_waddr = clr_addr;
        dv_we = 1'b1;
        dv_waddr = clr_addr;
        if (clr_addr == SLOT_W'(NUM_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        rd_en = 1'b1;
        state_next = ST_OP;
      end
      ST_OP: begin
        if (bad) begin
          op_err = 1'b1;
        end else begin
          unique case (item.mode)
            MODE_CHECK: begin
              op_err = item.write_back && !l0.ok;
              op_hz = |mask;
            end
            MODE_USES: begin
              op_err = item.write_back && !l0.ok;
            end
            MODE_SNAPSHOT: begin
              op_err = 1'b0;
            end
            MODE_RESERVE: begin
              if (!item.write_back || !l0.ok || l0.busy) begin
                op_err = 1'b1;
              end else begin
                busy_we = out_free;
                busy_val = 1'b1;
                own_we = out_free;
              end
            end
            MODE_RELEASE: begin
              if (!item.write_back || !l0.ok || !l0.busy) begin
                op_err = 1'b1;
              end else begin
                cnt_we = out_free;
                if (dv_rd) begin
                  own_we = out_free;
                  own_wdata = def_rd;
                  dv_we = out_free;
                end else begin
                  busy_we = out_free;
                end
              end
            end
            MODE_COMMIT: begin
              if (!l0.ok) begin
                op_err = 1'b1;
              end else begin
                cnt_we = out_free;
                cnt_wdata = cnt_inc;
                op_done = cnt_inc >= item.packet_count;
              end
            end
            MODE_RESTORE: begin
              if (!l0.ok) begin
                op_err = 1'b1;
              end else if (!l0.busy) begin
                busy_we = out_free;
                busy_val = 1'b1;
                own_we = out_free;
              end else begin
                def_we = out_free;
                dv_we = out_free;
                dv_wdata = 1'b1;
              end
            end
            default: begin
              op_err = 1'b1;
            end
          endcase
        end
        if (go_scan) begin
          state_next = ST_SCAN;
        end else if (out_free) begin
          emit = 1'b1;
          emit_pay = make_item(1'b1, 1'b0, op_hz, op_done, op_err, '0, '0, '0);
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        found = is_uses ? mask[lane_sel] : snap_hit;
        if (found) begin
          rd_en = 1'b1;
          rd_addr = scan_slot;
          if (is_snap) begin
            busy_we = 1'b1;
            busy_bank = bank_of(item.warp, int'(scan_t));
            busy_bit = scan_i;
            cnt_we = 1'b1;
            cnt_waddr = scan_slot;
          end
          state_next = ST_FETCH;
        end else if (scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FETCH: begin
        if (!held_v || out_free) begin
          if (held_v) begin
            emit = 1'b1;
            emit_pay = make_item(1'b0, 1'b1, res_hz, res_done, res_err, held_type, held_idx,
                                 held_rec);
          end
          state_next = scan_end ? ST_FINISH : ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          emit = 1'b1;
          if (held_v) begin
            emit_pay = make_item(1'b1, 1'b1, res_hz, res_done, res_err, held_type, held_idx,
                                 held_rec);
          end else begin
            emit_pay = make_item(1'b1, 1'b0, res_hz, res_done, res_err, '0, '0, '0);
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      held_v <= 1'b0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
      if (emit) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
      if (state == ST_IDLE) begin
        held_v <= 1'b0;
      end else if (state == ST_FETCH && state_next != ST_FETCH) begin
        held_v <= 1'b1;
      end else if (state == ST_FINISH && emit) begin
        held_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        busy[b] <= '0;
      end
    end else if (busy_we) begin
      busy[busy_bank][busy_bit] <= busy_val;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      opay <= emit_pay;
    end
    if (state == ST_IDLE && req.valid) begin
      item <= req.payload;
      lane_sel <= '0;
      scan_t <= '0;
      scan_i <= '0;
      rep_cnt <= '0;
    end
    if (state == ST_OP) begin
      res_err <= op_err;
      res_hz <= 1'b0;
      res_done <= 1'b0;
    end
    if (state == ST_SCAN) begin
      if (found) begin
        scan_end <= scan_last;
        cur_type <= is_uses ? lane_info[lane_sel].rtype : TYPE_W'(int'(scan_t) + 1);
        cur_idx <= is_uses ? lane_info[lane_sel].ridx : IDX_W'(scan_i);
        if (is_snap) begin
          rep_cnt <= rep_cnt + REP_W'(1);
        end
      end
      if (!scan_last) begin
        lane_sel <= lane_sel + LANE_W'(1);
        if (scan_i == RI_W'(REGS_PER_TYPE - 1)) begin
          scan_i <= '0;
          scan_t <= scan_t + T_W'(1);
        end else begin
          scan_i <= scan_i + RI_W'(1);
        end
      end
    end
    if (state == ST_FETCH && state_next != ST_FETCH) begin
      held_type <= cur_type;
      held_idx <= cur_idx;
      held_rec <= own_rd;
    end
  end

  wrs_ram #(.WIDTH(REC_W), .DEPTH(NUM_SLOTS)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(own_rd)
  );

  wrs_ram #(.WIDTH(REC_W), .DEPTH(NUM_SLOTS)) u_defer (
    .clk(clk), .we(def_we), .waddr(l0.slot), .wdata(rec_in),
    .re(rd_en), .raddr(rd_addr), .rdata(def_rd)
  );

  wrs_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SLOTS)) u_count (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(cnt_rd)
  );

  wrs_ram #(.WIDTH(1), .DEPTH(NUM_SLOTS)) u_dvalid (
    .clk(clk), .we(dv_we), .waddr(dv_waddr), .wdata(dv_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(dv_rd)
  );

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = ov;
  assign rsp.payload = opay;

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("scoreboard state is not one-hot");
  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !held_v)
    else $error("held report left over in idle");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.payload.report) |-> rsp.payload.last)
    else $error("status item not marked last");
  a_rep_cap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rep_cnt <= REP_W'(MAX_REPORTS)))
    else $error("snapshot report count over limit");
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> !emit || (state != ST_CLEAR))
    else $error("item emitted during clearing pass");
`endif
endmodule

>>> rtl/wrs_ram.sv
module wrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> rtl/wrs_lane.sv
module wrs_lane (
  input  logic [2:0]          warp,
  input  logic [6:0]          reg_code,
  input  wrs_pkg::busy_row_t  busy_row,
  output wrs_pkg::lane_t      info
);
  import wrs_pkg::*;

  logic [TYPE_W-1:0] rtype;
  logic [IDX_W-1:0]  ridx;
  logic              ok;

  assign rtype = reg_code[6:5];
  assign ridx  = reg_code[4:0];
  assign ok = (int'(warp) < NUM_WARPS) && (rtype != '0) && (int'(rtype) <= NUM_REG_TYPES)
              && (int'(ridx) < REGS_PER_TYPE);

  always_comb begin
    info.ok    = ok;
    info.rtype = rtype;
    info.ridx  = ridx;
    info.bank  = bank_of(warp, int'(rtype) - 1);
    info.slot  = slot_of(warp, int'(rtype) - 1, int'(ridx));
    info.busy  = ok ? busy_row[T_W'(int'(rtype) - 1)][RI_W'(ridx)] : 1'b0;
  end
endmodule

>>> sim/tb_if.sv
`timescale 1ns / 1ps
// The block's own interfaces (wrs_in_if, wrs_out_if) come from the RTL sources.
// This file holds the type that the bench uses to describe one row of stimulus.
package tb_stim_pkg;
  import wrs_pkg::*;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t first_result;
  } stim_row_t;
endpackage

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import wrs_pkg::*;
  import tb_stim_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 420;
  localparam int IN_W = $bits(in_item_t);

  logic clk;
  logic rst;
  wrs_in_if req ();
  wrs_out_if rsp ();

  warp_register_scoreboard dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  logic [31:0] busy_map [NUM_BANKS];
  logic [27:0] owner_map [NUM_SLOTS];
  logic [7:0]  count_map [NUM_SLOTS];
  bit          deferred_ok [NUM_SLOTS];
  logic [27:0] deferred_map [NUM_SLOTS];

  out_item_t expected_results [$];
  out_item_t typed_results [$];
  bit        typed_flags [$];
  stim_row_t table_rows [$];
  int        failures;
  int        cycles;

  function automatic bit reg_slot(input logic [2:0] warp, input logic [6:0] r,
                                  output int bank, output int slot);
    int rtype;
    rtype = r[6:5];
    bank = 0;
    slot = 0;
    if (warp >= NUM_WARPS || rtype < 1 || rtype > NUM_REG_TYPES || r[4:0] >= REGS_PER_TYPE)
      return 1'b0;
    bank = warp * NUM_REG_TYPES + rtype - 1;
    slot = bank * REGS_PER_TYPE + r[4:0];
    return 1'b1;
  endfunction

  function automatic out_item_t owned_result(input logic [1:0] rtype, input logic [4:0] idx,
                                             input logic [27:0] rec);
    out_item_t o;
    o = '0;
    o.report = 1'b1;
    o.reg_type = rtype;
    o.reg_index = idx;
    o.owner_tag_out = rec[27:12];
    o.owner_unit_out = rec[11:8];
    o.owner_op_out = rec[7:0];
    return o;
  endfunction

  task automatic predict_scoreboard(input in_item_t it);
    out_item_t found [$];
    out_item_t o;
    logic [6:0] srcs [3];
    logic [27:0] rec;
    bit err, hz, done;
    int bank, slot;
    found = {};
    err = 0;
    hz = 0;
    done = 0;
    rec = {it.owner_tag, it.owner_unit, it.owner_op};
    srcs[0] = it.src_reg_0;
    srcs[1] = it.src_reg_1;
    srcs[2] = it.src_reg_2;
    if (it.warp >= NUM_WARPS || it.mode > MODE_RESTORE) begin
      err = 1;
    end else if (it.mode == MODE_CHECK || it.mode == MODE_USES) begin
      if (it.write_back) begin
        if (!reg_slot(it.warp, it.dst_reg, bank, slot)) begin
          err = 1;
        end else if (busy_map[bank][it.dst_reg[4:0]]) begin
          hz = 1;
          found = {found, owned_result(it.dst_reg[6:5], it.dst_reg[4:0], owner_map[slot])};
        end
      end
      for (int i = 0; i < NUM_SOURCES; i++) begin
        if (srcs[i][6:5] != 0 && reg_slot(it.warp, srcs[i], bank, slot) &&
            busy_map[bank][srcs[i][4:0]]) begin
          hz = 1;
          found = {found, owned_result(srcs[i][6:5], srcs[i][4:0], owner_map[slot])};
        end
      end
      if (it.mode == MODE_CHECK) found = {};
      else hz = 0;
    end else if (it.mode == MODE_RESERVE) begin
      if (!it.write_back || !reg_slot(it.warp, it.dst_reg, bank, slot) ||
          busy_map[bank][it.dst_reg[4:0]]) begin
        err = 1;
      end else begin
        busy_map[bank][it.dst_reg[4:0]] = 1'b1;
        owner_map[slot] = rec;
      end
    end else if (it.mode == MODE_RELEASE) begin
      if (!it.write_back || !reg_slot(it.warp, it.dst_reg, bank, slot) ||
          !busy_map[bank][it.dst_reg[4:0]]) begin
        err = 1;
      end else begin
        count_map[slot] = 0;
        if (deferred_ok[slot]) begin
          owner_map[slot] = deferred_map[slot];
          deferred_ok[slot] = 0;
        end else begin
          busy_map[bank][it.dst_reg[4:0]] = 1'b0;
        end
      end
    end else if (it.mode == MODE_COMMIT) begin
      if (!reg_slot(it.warp, it.dst_reg, bank, slot)) begin
        err = 1;
      end else begin
        if (count_map[slot] != 8'hFF) count_map[slot]++;
        done = count_map[slot] >= it.packet_count;
      end
    end else if (it.mode == MODE_SNAPSHOT) begin
      for (int t = 0; t < NUM_REG_TYPES; t++) begin
        bank = it.warp * NUM_REG_TYPES + t;
        for (int x = 0; x < REGS_PER_TYPE; x++) begin
          slot = bank * REGS_PER_TYPE + x;
          if (busy_map[bank][x] && found.size() < MAX_REPORTS) begin
            found = {found, owned_result(2'(t + 1), 5'(x), owner_map[slot])};
            busy_map[bank][x] = 1'b0;
            count_map[slot] = 0;
          end
        end
      end
    end else begin
      if (!reg_slot(it.warp, it.dst_reg, bank, slot)) begin
        err = 1;
      end else if (!busy_map[bank][it.dst_reg[4:0]]) begin
        busy_map[bank][it.dst_reg[4:0]] = 1'b1;
        owner_map[slot] = rec;
      end else begin
        deferred_map[slot] = rec;
        deferred_ok[slot] = 1;
      end
    end
    if (found.size() == 0) begin
      o = '0;
      found = {found, o};
    end
    foreach (found[k]) begin
      o = found[k];
      o.last = (k == found.size() - 1);
      o.hazard = hz;
      o.done_res = done;
      o.error = err;
      expected_results = {expected_results, o};
    end
  endtask

  function automatic in_item_t make_item(input mode_e m, input int warp, input bit wb,
                                         input logic [6:0] dst, input logic [6:0] s0,
                                         input logic [6:0] s1, input logic [6:0] s2,
                                         input logic [15:0] tag, input logic [7:0] pk);
    in_item_t it;
    it.mode = m;
    it.warp = 3'(warp);
    it.write_back = wb;
    it.dst_reg = dst;
    it.src_reg_0 = s0;
    it.src_reg_1 = s1;
    it.src_reg_2 = s2;
    it.owner_tag = tag;
    it.owner_unit = tag[3:0];
    it.owner_op = tag[15:8];
    it.packet_count = pk;
    return it;
  endfunction

  function automatic stim_row_t row(input in_item_t it, input bit typed, input bit err);
    stim_row_t r;
    r.item = it;
    r.typed = typed;
    r.first_result = '0;
    r.first_result.last = 1'b1;
    r.first_result.error = err;
    return r;
  endfunction

  task automatic add_row(input in_item_t it, input bit typed, input bit err);
    table_rows = {table_rows, row(it, typed, err)};
  endtask

  function automatic logic [6:0] rand_reg(input bit hot);
    logic [6:0] r;
    if (hot) r = {2'(1 + $urandom_range(0, 1)), 5'($urandom_range(0, 3))};
    else r = 7'($urandom);
    return r;
  endfunction

  function automatic in_item_t rand_item(input int hot_warp);
    in_item_t it;
    int pick;
    bit hot;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    hot = $urandom_range(0, 9) != 0;
    pick = $urandom_range(0, 99);
    if (pick < 2) it.mode = 3'd7;
    else if (pick < 12) it.mode = MODE_CHECK;
    else if (pick < 27) it.mode = MODE_USES;
    else if (pick < 47) it.mode = MODE_RESERVE;
    else if (pick < 62) it.mode = MODE_RELEASE;
    else if (pick < 77) it.mode = MODE_COMMIT;
    else if (pick < 80) it.mode = MODE_SNAPSHOT;
    else it.mode = MODE_RESTORE;
    if (hot) begin
      it.warp = 3'(hot_warp);
      it.write_back = $urandom_range(0, 15) != 0;
      it.dst_reg = rand_reg(1);
      it.src_reg_0 = rand_reg(1);
      it.src_reg_1 = rand_reg(1);
      it.src_reg_2 = rand_reg($urandom_range(0, 1));
      it.packet_count = 8'($urandom_range(1, 6));
    end
    if (it.packet_count == 0) it.packet_count = 8'd1;
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t first);
    int gap;
    gap = 0;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= it;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_scoreboard(it);
    typed_flags = {typed_flags, typed};
    typed_results = {typed_results, first};
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      out_item_t want;
      out_item_t got;
      got = rsp.payload;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
          failures++;
        end
      end
      if (got.last && typed_flags.size() != 0) begin
        if (typed_flags[0] && got !== typed_results[0]) begin
          $display("%0t: table mismatch, expected %p, actual %p", $time, typed_results[0],
                   got);
          failures++;
        end
        void'(typed_flags.pop_front());
        void'(typed_results.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 1) == 0) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(0, 4) != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    out_item_t none;
    none = '0;
    failures = 0;
    cycles = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.payload = '0;
    rsp.ready = 1'b1;
    foreach (busy_map[b]) busy_map[b] = '0;
    foreach (count_map[s]) begin
      count_map[s] = '0;
      deferred_ok[s] = 0;
      owner_map[s] = '0;
      deferred_map[s] = '0;
    end
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    add_row(make_item(MODE_CHECK, 0, 1, 7'h20, 7'h21, 7'h40, 7'h5F, 0, 1), 1, 0);
    add_row(make_item(MODE_USES, 7, 1, 7'h5F, 7'h3F, 7'h40, 7'h00, 0, 1), 1, 0);
    add_row(make_item(MODE_RESERVE, 0, 1, 7'h20, 0, 0, 0, 16'hFFFF, 1), 1, 0);
    add_row(make_item(MODE_RESERVE, 0, 1, 7'h20, 0, 0, 0, 16'h1234, 1), 1, 1);
    add_row(make_item(MODE_RESERVE, 7, 1, 7'h5F, 0, 0, 0, 16'h0000, 1), 1, 0);
    add_row(make_item(MODE_RESERVE, 0, 0, 7'h21, 0, 0, 0, 1, 1), 1, 1);
    add_row(make_item(MODE_RESERVE, 0, 1, 7'h61, 0, 0, 0, 1, 1), 1, 1);
    add_row(make_item(MODE_CHECK, 0, 1, 7'h20, 7'h5F, 0, 0, 0, 1), 0, 0);
    add_row(make_item(MODE_USES, 0, 1, 7'h20, 7'h20, 7'h41, 7'h20, 0, 1), 0, 0);
    add_row(make_item(MODE_USES, 0, 1, 7'h7F, 7'h20, 7'h00, 7'h00, 0, 1), 0, 0);
    add_row(make_item(MODE_COMMIT, 0, 0, 7'h20, 0, 0, 0, 0, 8'd1), 0, 0);
    add_row(make_item(MODE_COMMIT, 0, 0, 7'h20, 0, 0, 0, 0, 8'd255), 0, 0);
    add_row(make_item(MODE_COMMIT, 0, 0, 7'h00, 0, 0, 0, 0, 8'd1), 1, 1);
    add_row(make_item(MODE_RESTORE, 0, 1, 7'h20, 0, 0, 0, 16'hABCD, 1), 0, 0);
    add_row(make_item(MODE_RELEASE, 0, 1, 7'h20, 0, 0, 0, 0, 1), 0, 0);
    add_row(make_item(MODE_CHECK, 0, 1, 7'h20, 0, 0, 0, 0, 1), 0, 0);
    add_row(make_item(MODE_RELEASE, 0, 1, 7'h20, 0, 0, 0, 0, 1), 0, 0);
    add_row(make_item(MODE_RELEASE, 0, 1, 7'h20, 0, 0, 0, 0, 1), 1, 1);
    add_row(make_item(MODE_RELEASE, 0, 0, 7'h20, 0, 0, 0, 0, 1), 1, 1);
    add_row(make_item(MODE_RESTORE, 0, 1, 7'h45, 0, 0, 0, 16'h00FF, 1), 0, 0);
    add_row(make_item(MODE_RESTORE, 0, 1, 7'h60, 0, 0, 0, 0, 1), 1, 1);
    add_row(make_item(MODE_SNAPSHOT, 0, 0, 0, 0, 0, 0, 0, 1), 0, 0);
    add_row(make_item(MODE_SNAPSHOT, 0, 0, 0, 0, 0, 0, 0, 1), 1, 0);
    it = make_item(MODE_CHECK, 3, 1, 7'h20, 0, 0, 0, 0, 1);
    it.mode = 3'd7;
    add_row(it, 1, 1);
    for (int r = 0; r < 64; r++) begin
      add_row(make_item(MODE_RESERVE, 5, 1, {2'(1 + r / 32), 5'(r % 32)},
                        0, 0, 0, 16'(r), 1), 0, 0);
    end
    add_row(make_item(MODE_SNAPSHOT, 5, 0, 0, 0, 0, 0, 0, 1), 0, 0);

    foreach (table_rows[i]) begin
      send_item(table_rows[i].item, table_rows[i].typed, table_rows[i].first_result);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      send_item(rand_item((n / 60) % NUM_WARPS), 0, none);
    end
    wait_drained();
    repeat (200) @(negedge clk);
    if (failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
